@@ rtl/signed_integer_divider_macros.svh @@
// Assertion macros shared by the signed divider checker.
`ifndef SIGNED_INTEGER_DIVIDER_MACROS_SVH
`define SIGNED_INTEGER_DIVIDER_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is held.
`define SID_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with the clock and reset names fixed to the block's ports.
`define SID_ASSERT(name, prop, msg) \
  `SID_ASSERT_CLK(name, clk, rst_n, prop, msg)

`endif

@@ rtl/sid_pkg.sv @@
// Package with widths, constants and stage types of the signed divider.
package sid_pkg;

  localparam int DATA_WIDTH = 32;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  // Bit positions of the result flags in out_tuser.
  localparam int TUSER_OVERFLOW = 0;
  localparam int TUSER_DIV_ZERO = 1;

  localparam logic [DATA_WIDTH-1:0] MOST_NEG  = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS  = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};

  // One pipeline slot: partial remainder, dividend bits still to shift in
  // sharing a register with the quotient bits already produced, the divisor
  // magnitude, and the sign and special-case flags that ride along.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] nq;
    logic [DATA_WIDTH-1:0] den;
    logic                  neg;
    logic                  ovf;
    logic                  dbz;
  } sid_stage_t;

endpackage

@@ rtl/signed_integer_divider.sv @@
// Pipelined signed integer divider, one restoring step per subtract stage.
// Stages in order: the operand stage, 31 subtract stages, then the last step and
// the sign fix in the output stage.
// Throughput: one item per cycle while the output is not stalled; the subtract pipeline sets the depth.
// A stalled output freezes the whole pipeline, and in_tready follows it.
// Reset (rst_n low at a clock edge) clears all valid bits; data is not reset.
module signed_integer_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata from bit 0 up: numerator, denominator, zero fill
  input  logic [sid_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata from bit 0 up: quotient, zero fill
  output logic [sid_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser from bit 0 up: overflow, divide_by_zero
  output logic [sid_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import sid_pkg::*;

  localparam int W = DATA_WIDTH;

  // One radix-2 restoring step: shift the next dividend bit into the
  // remainder, subtract the divisor if it fits, and shift the quotient bit in.
  function automatic sid_stage_t div_step(sid_stage_t s);
    sid_stage_t      r;
    logic [W:0]      trial;
    logic [W:0]      diff;
    logic            fits;
    r     = s;
    trial = {s.rem, s.nq[W-1]};
    diff  = trial - {1'b0, s.den};
    fits  = ~diff[W];
    r.rem = fits ? diff[W-1:0] : trial[W-1:0];
    r.nq  = {s.nq[W-2:0], fits};
    return r;
  endfunction

  logic                    en;
  logic                    accept;
  logic [W-1:0]            numerator;
  logic [W-1:0]            denominator;
  sid_stage_t              load;

  // Stage 0 holds the magnitudes; stage k has taken k restoring steps.
  sid_stage_t              stg_r [0:W-1];
  logic                    vld_r [0:W-1];

  logic [W-1:0]            quot_fixed;
  logic [W-1:0]            quot_final;
  sid_stage_t              last_step;

  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_nxt;
  logic [OUT_TUSER_W-1:0]  out_tuser_r;
  logic [OUT_TUSER_W-1:0]  out_tuser_nxt;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en        = ~out_valid_r | out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid & en;

  assign numerator   = in_tdata[W-1:0];
  assign denominator = in_tdata[2*W-1:W];

  // Operand stage: take magnitudes and note the sign of the result and the
  // two special cases. No restoring step is taken here; the last one sits in
  // the output stage, so every stage in between takes exactly one step.
  always_comb begin
    sid_stage_t mag;
    mag.rem = '0;
    mag.nq  = numerator[W-1] ? (~numerator + 1'b1) : numerator;
    mag.den = denominator[W-1] ? (~denominator + 1'b1) : denominator;
    mag.neg = numerator[W-1] ^ denominator[W-1];
    mag.dbz = (denominator == '0);
    mag.ovf = (numerator == MOST_NEG) && (denominator == MINUS_ONE);
    load    = mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= load;
    end
  end

  // Restoring steps one through W-1, one register stage each.
  for (genvar k = 0; k < W - 1; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k+1] <= div_step(stg_r[k]);
      end
    end
  end

  // Output stage: the final restoring step, then the sign fix and the
  // special-case overrides (zero divisor wins, then saturation).
  assign last_step  = div_step(stg_r[W-1]);
  assign quot_fixed = last_step.neg ? (~last_step.nq + 1'b1) : last_step.nq;

  always_comb begin
    priority if (last_step.dbz) begin
      quot_final = '0;
    end else if (last_step.ovf) begin
      quot_final = MOST_POS;
    end else begin
      quot_final = quot_fixed;
    end
    out_tdata_nxt                 = OUT_TDATA_W'(quot_final);
    out_tuser_nxt                 = '0;
    out_tuser_nxt[TUSER_OVERFLOW] = last_step.ovf & ~last_step.dbz;
    out_tuser_nxt[TUSER_DIV_ZERO] = last_step.dbz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

@@ rtl/sid_checker.sv @@
// Port-level checker for the signed divider and its bind statement.
`include "signed_integer_divider_macros.svh"

module sid_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [sid_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sid_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [sid_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import sid_pkg::*;

  logic [DATA_WIDTH-1:0] quot;
  logic                  in_seen;
  assign quot    = out_tdata[DATA_WIDTH-1:0];
  assign in_seen = in_tvalid | (in_tdata != '0);

  `SID_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `SID_ASSERT(a_stall_blocks_input, out_tvalid && !out_tready |-> !in_tready, "input taken while output stalled")
  `SID_ASSERT(a_flags_exclusive, out_tvalid |-> !(out_tuser[TUSER_OVERFLOW] && out_tuser[TUSER_DIV_ZERO]), "both flags set")
  `SID_ASSERT(a_div_zero_quot, out_tvalid && out_tuser[TUSER_DIV_ZERO] |-> quot == '0 || !in_seen && quot == '0, "zero divisor result not zero")
  `SID_ASSERT(a_overflow_quot, out_tvalid && out_tuser[TUSER_OVERFLOW] |-> quot == MOST_POS, "overflow result not saturated")

endmodule

bind signed_integer_divider sid_checker u_sid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ dv/sid_quotient_checker.sv @@
// Watches both streams of the signed divider, predicts each quotient and compares it.
`timescale 1ns / 100ps

module sid_quotient_checker
  import sid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  output int unsigned            mismatch_count,
  output int unsigned            quotients_owed
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient;
    logic                  overflow;
    logic                  divide_by_zero;
  } quotient_result_t;

  quotient_result_t owed_q[$];

  // Truncating signed division on the magnitudes, one restoring step per bit.
  function automatic quotient_result_t divide_signed(input logic [DATA_WIDTH-1:0] num,
                                                     input logic [DATA_WIDTH-1:0] den);
    quotient_result_t res;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH:0]   part;
    int                    i;
    res = '0;
    if (den == '0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    if (num == MOST_NEG && den == MINUS_ONE) begin
      res.quotient = MOST_POS;
      res.overflow = 1'b1;
      return res;
    end
    num_mag = num[DATA_WIDTH-1] ? -num : num;
    den_mag = den[DATA_WIDTH-1] ? -den : den;
    part = '0;
    quo  = '0;
    for (i = DATA_WIDTH - 1; i >= 0; i--) begin
      part = {part[DATA_WIDTH-1:0], num_mag[i]};
      if (part >= {1'b0, den_mag}) begin
        part   = part - {1'b0, den_mag};
        quo[i] = 1'b1;
      end
    end
    res.quotient = (num[DATA_WIDTH-1] != den[DATA_WIDTH-1]) ? -quo : quo;
    return res;
  endfunction

  initial begin
    mismatch_count = 0;
    quotients_owed = 0;
  end

  always @(posedge clk) begin
    quotient_result_t want;
    int unsigned      bad;
    bad = 0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          $error("result item with no quotient expected: quotient %0d, tuser %b",
                 $signed(out_tdata[DATA_WIDTH-1:0]), out_tuser);
          bad++;
        end else begin
          want = owed_q.pop_front();
          if (out_tdata[DATA_WIDTH-1:0] !== want.quotient) begin
            $error("quotient: expected %0d, actual %0d",
                   $signed(want.quotient), $signed(out_tdata[DATA_WIDTH-1:0]));
            bad++;
          end
          if (out_tuser[TUSER_OVERFLOW] !== want.overflow) begin
            $error("overflow: expected %b, actual %b", want.overflow,
                   out_tuser[TUSER_OVERFLOW]);
            bad++;
          end
          if (out_tuser[TUSER_DIV_ZERO] !== want.divide_by_zero) begin
            $error("divide_by_zero: expected %b, actual %b", want.divide_by_zero,
                   out_tuser[TUSER_DIV_ZERO]);
            bad++;
          end
        end
      end
      if (in_tvalid && in_tready)
        owed_q.push_back(divide_signed(in_tdata[DATA_WIDTH-1:0],
                                       in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
    end
    mismatch_count <= mismatch_count + bad;
    quotients_owed <= owed_q.size();
  end

endmodule

@@ dv/signed_integer_divider_tb.sv @@
// Top of the signed divider testbench: clock, reset, operand stimulus and verdict.
`timescale 1ns / 100ps

module signed_integer_divider_tb;
  import sid_pkg::*;

  // Random operand pairs after the directed ones.
  localparam int RANDOM_ITEMS = 800;
  // The receiver holds off once this many items have gone in.
  localparam int HOLD_AFTER_ITEMS = 200;
  // Long enough for the 33-stage pipeline to fill and push back on the input.
  localparam int HOLD_CYCLES = 150;
  // Pipeline latency plus margin, waited out once nothing more is owed.
  localparam int DRAIN_CYCLES = 40;

  // Ways the receiver drives out_tready during one stretch.
  typedef enum int {
    READY_ALWAYS,
    READY_COIN_FLIP,
    READY_ONE_IN_FOUR,
    READY_MOSTLY
  } ready_pattern_e;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int unsigned checker_errors;
  int unsigned quotients_owed;

  // First two shared by sender and receiver; all only shape the stimulus.
  int unsigned items_sent;
  bit          holding_off;
  int          burst_left;

  signed_integer_divider uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sid_quotient_checker u_quotient_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (checker_errors),
    .quotients_owed (quotients_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Presents one operand pair and holds it until the divider takes it. The
  // sender runs in bursts: when a burst is used up it drops in_tvalid for a
  // random gap and drives junk on in_tdata meanwhile, which the block must
  // ignore. No gaps are taken while the receiver is holding off, so the
  // pipeline really fills and in_tready has to fall.
  task automatic offer(input logic [DATA_WIDTH-1:0] num, input logic [DATA_WIDTH-1:0] den);
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    word = '0;
    word[DATA_WIDTH-1:0] = num;
    word[2*DATA_WIDTH-1:DATA_WIDTH] = den;
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      if (!holding_off) begin
        gap = $urandom_range(1, 14);
        in_tvalid <= 1'b0;
        repeat (gap) begin
          in_tdata <= {$urandom, $urandom};
          @(posedge clk);
        end
      end
    end
  endtask

  // Mixes full-range words, values of every magnitude with either sign, small
  // values (zero among them) and the extremes of the signed range.
  function automatic logic [DATA_WIDTH-1:0] pick_operand();
    logic [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6: begin
        v = $urandom >> $urandom_range(0, DATA_WIDTH - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      7: begin
        v = $urandom_range(0, 15);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = MINUS_ONE;
          3: v = 1;
          4: v = '0;
          default: v = MOST_NEG + 1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Receiver: cycles through stretches of different ready patterns, so that
  // stalls land on every phase of the pipeline, including stretches with no
  // stall at all. Once, after enough items have gone in, it holds out_tready
  // low for a long count of cycles while the sender keeps offering items.
  initial begin : receiver
    ready_pattern_e pattern;
    int             span;
    int             k;
    bit             hold_done;
    hold_done   = 1'b0;
    holding_off = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AFTER_ITEMS) begin
        holding_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding_off = 1'b0;
        hold_done   = 1'b1;
      end
      pattern = ready_pattern_e'($urandom_range(0, 3));
      span    = $urandom_range(16, 160);
      for (k = 0; k < span; k++) begin
        case (pattern)
          READY_ALWAYS:      out_tready <= 1'b1;
          READY_COIN_FLIP:   out_tready <= ($urandom_range(0, 1) == 1);
          READY_ONE_IN_FOUR: out_tready <= (k % 4 == 0);
          default:           out_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Sender and verdict.
  initial begin : stimulus
    int n;
    logic [DATA_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0] den;
    items_sent = 0;
    burst_left = $urandom_range(1, 48);
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items: zero divisors, the saturating most-negative by minus one
    // case, most-negative by plus one, extremes against extremes and every
    // sign combination of an ordinary quotient.
    offer('0, '0);
    offer(5, '0);
    offer(MOST_NEG, '0);
    offer(MOST_POS, '0);
    offer(MOST_NEG, MINUS_ONE);
    offer(MOST_NEG, 1);
    offer(MOST_POS, 1);
    offer(MOST_POS, MINUS_ONE);
    offer(MOST_NEG, MOST_NEG);
    offer(MOST_POS, MOST_NEG);
    offer(MOST_NEG, MOST_POS);
    offer(MOST_POS, MOST_POS);
    offer(MINUS_ONE, MOST_NEG);
    offer(MINUS_ONE, MINUS_ONE);
    offer(7, 2);
    offer(-7, 2);
    offer(7, -2);
    offer(-7, -2);
    offer(1, MOST_POS);
    offer('0, MINUS_ONE);
    offer(100, 7);
    offer(MOST_NEG, 2);
    offer(MOST_NEG, -2);
    offer(12345, MINUS_ONE);

    // Random pairs, with a steady share of the special divisors against the
    // most negative dividend so those corners come up again under stalls.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 32) == 0) begin
        num = MOST_NEG;
        case ($urandom_range(0, 2))
          0:       den = MINUS_ONE;
          1:       den = 1;
          default: den = '0;
        endcase
      end else begin
        num = pick_operand();
        den = pick_operand();
      end
      offer(num, den);
    end
    in_tvalid <= 1'b0;

    // Let the checker see the last accepted item, then drain the pipeline.
    @(posedge clk);
    while (quotients_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (checker_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a run that never finishes ends here with the error verdict.
  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
